// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_SYNC_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/llpf_pkg.sv -----
package llpf_pkg;

   localparam int NumPatternRegs = 4;
   localparam int PatternLenBits = 4;
   localparam int SegLenBits     = 16;
   localparam int CsrDataBits    = 64;
   localparam int CsrAddrBits    = 6;

   localparam int QueueDepth     = 4;
   localparam int QueuePtrBits   = $clog2(QueueDepth);
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   localparam logic [7:0] ByteNl  = 8'h0A;
   localparam logic [7:0] ByteNul = 8'h00;
   localparam logic [7:0] ByteBar = 8'h7C;
   localparam logic [7:0] ByteSp  = 8'h20;
   localparam logic [7:0] ByteCr  = 8'h0D;

   typedef enum logic [2:0] {
      CsrFilterEnable  = 3'd0,
      CsrPatternCount  = 3'd1,
      CsrPatternLengths = 3'd2,
      CsrPatternA      = 3'd3,
      CsrPatternB      = 3'd4,
      CsrPatternC      = 3'd5,
      CsrPatternD      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                               filter_enable;
      logic [2:0]                         pattern_count;
      logic [15:0]                        pattern_lengths;
      logic [NumPatternRegs-1:0][63:0]    pattern;
   } cfg_type;

   // One finished segment, handed from the front to the back.
   typedef struct packed {
      logic [SegLenBits-1:0] seg_len;
      logic                  hit;
      logic                  bar;
      logic                  nul;
   } seg_rec_type;

endpackage

// ----- rtl/llpf_if.sv -----
interface llpf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface llpf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] segment_length;
   logic        keep;
   logic        ended_by;

   modport source (output valid, output segment_length, output keep, output ended_by,
                   input ready);
   modport sink (input valid, input segment_length, input keep, input ended_by,
                 output ready);
endinterface

// ----- rtl/llpf_front.sv -----
module llpf_front #(
   parameter int NUM_PATTERNS  = 4,
   parameter int PATTERN_BYTES = 8,
   parameter int LENGTH_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   llpf_req_if.sink              req,
   input  llpf_pkg::cfg_type     cfg,
   input  logic                  queue_full,
   output logic                  push,
   output llpf_pkg::seg_rec_type push_rec
);

   localparam int ActivePatterns = (NUM_PATTERNS < llpf_pkg::NumPatternRegs) ?
                                   NUM_PATTERNS : llpf_pkg::NumPatternRegs;
   localparam int WindowBits     = (PATTERN_BYTES + 1) * 8;
   localparam int RecentBits     = PATTERN_BYTES * 8;

   logic [RecentBits-1:0]  recent_ff, recent_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   match_ff, match_in;
   logic                   bar_ff, bar_in;

   logic [WindowBits-1:0]      window;
   logic                       accept;
   logic                       is_term;
   logic [LENGTH_BITS-1:0]     count_sat;
   logic [LENGTH_BITS+15:0]    seg_len_ext;

   logic [llpf_pkg::PatternLenBits-1:0] raw_len [ActivePatterns];
   logic [llpf_pkg::PatternLenBits-1:0] pat_len [ActivePatterns];
   logic [15:0]                         eq_by_len [ActivePatterns];
   logic [ActivePatterns-1:0]           active;
   logic [ActivePatterns-1:0]           hit;
   logic [ActivePatterns-1:0]           zero_len;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign is_term   = (req.data_byte == llpf_pkg::ByteNl) ||
                      (req.data_byte == llpf_pkg::ByteNul);
   assign window    = {recent_ff, req.data_byte};
   assign count_sat = (&count_ff) ? count_ff : count_ff + LENGTH_BITS'(1);

   // Pattern char 0 lines up with the oldest of the last pattern-length bytes of the window.
   always_comb begin
      for (int k = 0; k < ActivePatterns; k++) begin
         raw_len[k] = cfg.pattern_lengths[4*k +: 4];
         pat_len[k] = (raw_len[k] > 4'(PATTERN_BYTES)) ? 4'(PATTERN_BYTES) : raw_len[k];
         active[k]  = cfg.pattern_count > 3'(k);
         eq_by_len[k] = '0;
         for (int l = 1; l <= PATTERN_BYTES; l++) begin
            eq_by_len[k][l] = 1'b1;
            for (int i = 0; i < l; i++) begin
               if (cfg.pattern[k][8*i +: 8] != window[8*(l-1-i) +: 8]) begin
                  eq_by_len[k][l] = 1'b0;
               end
            end
         end
         zero_len[k] = active[k] && (pat_len[k] == '0);
         hit[k]      = active[k] && (pat_len[k] != '0) &&
                       (count_ff >= LENGTH_BITS'(pat_len[k] - 4'd1)) &&
                       eq_by_len[k][pat_len[k]];
      end
   end

   always_comb begin
      recent_in = recent_ff;
      count_in  = count_ff;
      match_in  = match_ff;
      bar_in    = bar_ff;
      if (accept) begin
         if (is_term) begin
            recent_in = '0;
            count_in  = '0;
            match_in  = 1'b0;
            bar_in    = 1'b0;
         end else begin
            recent_in = window[RecentBits-1:0];
            count_in  = count_sat;
            match_in  = match_ff | (|hit);
            if (req.data_byte != llpf_pkg::ByteSp && req.data_byte != llpf_pkg::ByteCr) begin
               bar_in = (req.data_byte == llpf_pkg::ByteBar);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         count_ff  <= '0;
         match_ff  <= 1'b0;
         bar_ff    <= 1'b0;
      end else begin
         recent_ff <= recent_in;
         count_ff  <= count_in;
         match_ff  <= match_in;
         bar_ff    <= bar_in;
      end
   end

   // Length includes the terminator; saturates, then keeps the low field bits.
   assign seg_len_ext = (LENGTH_BITS + 16)'(count_sat);

   assign push             = accept && is_term;
   assign push_rec.seg_len = seg_len_ext[llpf_pkg::SegLenBits-1:0];
   assign push_rec.hit     = match_ff | (|zero_len);
   assign push_rec.bar     = bar_ff;
   assign push_rec.nul     = (req.data_byte == llpf_pkg::ByteNul);

endmodule

// ----- rtl/llpf_queue.sv -----
module llpf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  llpf_pkg::seg_rec_type push_rec,
   input  logic                  pop,
   output llpf_pkg::seg_rec_type head_rec,
   output logic                  empty,
   output logic                  full
);

   llpf_pkg::seg_rec_type entries_ff [llpf_pkg::QueueDepth];

   logic [llpf_pkg::QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [llpf_pkg::QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [llpf_pkg::QueueCountBits-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == llpf_pkg::QueueCountBits'(llpf_pkg::QueueDepth));
   assign head_rec = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + llpf_pkg::QueuePtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + llpf_pkg::QueuePtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + llpf_pkg::QueueCountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - llpf_pkg::QueueCountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ----- rtl/llpf_back.sv -----
module llpf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  filter_enable,
   input  logic                  queue_empty,
   input  llpf_pkg::seg_rec_type head_rec,
   output logic                  pop,
   llpf_rsp_if.source            rsp
);

   logic        prev_kept_ff, prev_kept_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_len_ff;
   logic        out_keep_ff, out_nul_ff;
   logic        keep;

   assign pop = !queue_empty && (!out_valid_ff || rsp.ready);

   // Carry: a kept line followed by a line ending in '|' is kept once.
   always_comb begin
      prev_kept_in = prev_kept_ff;
      keep         = 1'b1;
      priority if (head_rec.nul) begin
         keep = 1'b1;
      end else if (prev_kept_ff && head_rec.bar) begin
         keep         = 1'b1;
         prev_kept_in = 1'b0;
      end else begin
         keep         = head_rec.hit;
         prev_kept_in = head_rec.hit;
      end
      if (!filter_enable) begin
         keep = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_kept_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            prev_kept_ff <= prev_kept_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_len_ff  <= head_rec.seg_len;
         out_keep_ff <= keep;
         out_nul_ff  <= head_rec.nul;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.segment_length = out_len_ff;
   assign rsp.keep           = out_keep_ff;
   assign rsp.ended_by       = out_nul_ff;

endmodule

// ----- rtl/log_line_pattern_filter.sv -----
// Splits a log byte stream into segments ended by newline or NUL and reports one item per
// segment: its length with the terminator, a keep flag and the terminator kind. One byte is
// taken every cycle while the segment queue has room; all active patterns are compared in
// parallel against a shift window of the last PATTERN_BYTES bytes in the front stage, so
// the rate is kept. A result is registered in the queue, then in an output register, after
// its terminator is accepted, and the four-entry queue lets the byte side run on while
// results stall. Registers are 64 bits at byte address 8*i: filter enable, pattern count,
// pattern lengths, then patterns A to D; write only while no segment is in flight.
module log_line_pattern_filter #(
   parameter int NUM_PATTERNS  = 4,
   parameter int PATTERN_BYTES = 8,
   parameter int LENGTH_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   llpf_req_if.sink                            req,
   llpf_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [llpf_pkg::CsrAddrBits-1:0]    paddr,
   input  logic [llpf_pkg::CsrDataBits-1:0]    pwdata,
   output logic [llpf_pkg::CsrDataBits-1:0]    prdata,
   output logic                                pready
);

   llpf_pkg::cfg_type       cfg_ff, cfg_in;
   llpf_pkg::csr_index_type csr_index;
   logic                    csr_write;

   logic                  push, pop, queue_empty, queue_full;
   llpf_pkg::seg_rec_type push_rec, head_rec;

   assign pready    = 1'b1;
   assign csr_index = llpf_pkg::csr_index_type'(paddr[5:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            llpf_pkg::CsrFilterEnable:   cfg_in.filter_enable   = pwdata[0];
            llpf_pkg::CsrPatternCount:   cfg_in.pattern_count   = pwdata[2:0];
            llpf_pkg::CsrPatternLengths: cfg_in.pattern_lengths = pwdata[15:0];
            llpf_pkg::CsrPatternA:       cfg_in.pattern[0]      = pwdata;
            llpf_pkg::CsrPatternB:       cfg_in.pattern[1]      = pwdata;
            llpf_pkg::CsrPatternC:       cfg_in.pattern[2]      = pwdata;
            llpf_pkg::CsrPatternD:       cfg_in.pattern[3]      = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         llpf_pkg::CsrFilterEnable:   prdata = 64'(cfg_ff.filter_enable);
         llpf_pkg::CsrPatternCount:   prdata = 64'(cfg_ff.pattern_count);
         llpf_pkg::CsrPatternLengths: prdata = 64'(cfg_ff.pattern_lengths);
         llpf_pkg::CsrPatternA:       prdata = cfg_ff.pattern[0];
         llpf_pkg::CsrPatternB:       prdata = cfg_ff.pattern[1];
         llpf_pkg::CsrPatternC:       prdata = cfg_ff.pattern[2];
         llpf_pkg::CsrPatternD:       prdata = cfg_ff.pattern[3];
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   llpf_front #(
      .NUM_PATTERNS  (NUM_PATTERNS),
      .PATTERN_BYTES (PATTERN_BYTES),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   llpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   llpf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .filter_enable (cfg_ff.filter_enable),
      .queue_empty   (queue_empty),
      .head_rec      (head_rec),
      .pop           (pop),
      .rsp           (rsp)
   );

endmodule

// ----- rtl/llpf_checker.sv -----
`include "assert_macros.svh"

module llpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_segment_length,
   input logic        rsp_keep,
   input logic        rsp_ended_by
);

   logic [3:0] pending_ff, pending_in;
   logic       term_accept;
   logic       rsp_accept;

   assign term_accept = req_valid && req_ready &&
                        (req_data_byte == llpf_pkg::ByteNl ||
                         req_data_byte == llpf_pkg::ByteNul);
   assign rsp_accept  = rsp_valid && rsp_ready;

   // Segments terminated but not yet reported.
   always_comb begin
      pending_in = pending_ff;
      if (term_accept && !rsp_accept) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_accept && !term_accept) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_SYNC(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segment_length) && $stable(rsp_keep) && $stable(rsp_ended_by), "result changed while stalled")
   `ASSERT_SYNC(a_no_spurious, clock, reset, rsp_valid |-> pending_ff != 4'd0, "result without a terminated segment")
   `ASSERT_SYNC(a_nul_kept, clock, reset, rsp_valid && rsp_ended_by |-> rsp_keep, "NUL segment not kept")
   `ASSERT_SYNC_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind log_line_pattern_filter llpf_checker u_llpf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .req_data_byte      (req.data_byte),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_segment_length (rsp.segment_length),
   .rsp_keep           (rsp.keep),
   .rsp_ended_by       (rsp.ended_by)
);
